>>> hdl/mpab_pkg.sv
// mpab_pkg: shared types and constants of the multi-pattern automaton builder
// field widths, request opcodes, result status codes, sequencer step codes
// no dependencies
package mpab_pkg;

    localparam int OPCODE_W = 2;
    localparam int BYTE_W   = 8;
    localparam int QSTATE_W = 8;
    localparam int STATUS_W = 2;
    localparam int GSTATE_W = 8;
    localparam int FSTATE_W = 8;
    localparam int MASK_W   = 16;
    localparam int COUNT_W  = 9;

    localparam logic [OPCODE_W-1:0] OP_CLEAR = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_LOAD  = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_BUILD = 2'd2;
    localparam logic [OPCODE_W-1:0] OP_QUERY = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK            = 2'd0;
    localparam logic [STATUS_W-1:0] ST_STATES_FULL   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_KEYWORDS_FULL = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_BUILT     = 2'd3;

    localparam int STEP_W = 5;
    localparam logic [STEP_W-1:0] S_SWEEP     = 5'd0;
    localparam logic [STEP_W-1:0] S_IDLE      = 5'd1;
    localparam logic [STEP_W-1:0] S_LD_RD     = 5'd2;
    localparam logic [STEP_W-1:0] S_LD_EV     = 5'd3;
    localparam logic [STEP_W-1:0] S_LD_ORD    = 5'd4;
    localparam logic [STEP_W-1:0] S_LD_OWR    = 5'd5;
    localparam logic [STEP_W-1:0] S_Q_RD      = 5'd6;
    localparam logic [STEP_W-1:0] S_Q_EV      = 5'd7;
    localparam logic [STEP_W-1:0] S_B_OWN0_RD = 5'd8;
    localparam logic [STEP_W-1:0] S_B_OWN0_WR = 5'd9;
    localparam logic [STEP_W-1:0] S_B_R_RD    = 5'd10;
    localparam logic [STEP_W-1:0] S_B_R_EV    = 5'd11;
    localparam logic [STEP_W-1:0] S_B_R_WR    = 5'd12;
    localparam logic [STEP_W-1:0] S_B_Q       = 5'd13;
    localparam logic [STEP_W-1:0] S_B_S       = 5'd14;
    localparam logic [STEP_W-1:0] S_B_SF      = 5'd15;
    localparam logic [STEP_W-1:0] S_B_C_RD    = 5'd16;
    localparam logic [STEP_W-1:0] S_B_C_EV    = 5'd17;
    localparam logic [STEP_W-1:0] S_B_W_RD    = 5'd18;
    localparam logic [STEP_W-1:0] S_B_W_EV    = 5'd19;
    localparam logic [STEP_W-1:0] S_B_M_WR    = 5'd20;
    localparam logic [STEP_W-1:0] S_EMIT      = 5'd21;

    typedef struct packed {
        logic [STEP_W-1:0] step;
        logic              accept;
        logic              out_load;
    } cmd_t;

    typedef struct packed {
        logic sweep_last;
        logic kw_full;
        logic discarding;
        logic e_zero;
        logic e_ge2;
        logic root_enq;
        logic ld_record;
        logic c_last;
        logic head_lt_tail;
    } sts_t;

endpackage

>>> hdl/mpab_ifs.sv
// mpab_req_if / mpab_rsp_if: valid-ready channels for requests and results
// depends on mpab_pkg for field widths
interface mpab_req_if;
    logic                          valid;
    logic                          ready;
    logic [mpab_pkg::OPCODE_W-1:0] opcode;
    logic [mpab_pkg::BYTE_W-1:0]   byte_value;
    logic                          end_of_keyword;
    logic [mpab_pkg::QSTATE_W-1:0] query_state;

    modport source (output valid, opcode, byte_value, end_of_keyword, query_state,
                    input ready);
    modport sink (input valid, opcode, byte_value, end_of_keyword, query_state,
                  output ready);
endinterface

interface mpab_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [mpab_pkg::STATUS_W-1:0] status;
    logic                          goto_valid;
    logic [mpab_pkg::GSTATE_W-1:0] goto_state;
    logic [mpab_pkg::FSTATE_W-1:0] failure_state;
    logic [mpab_pkg::MASK_W-1:0]   match_mask;
    logic [mpab_pkg::COUNT_W-1:0]  state_count;

    modport source (output valid, status, goto_valid, goto_state, failure_state,
                    match_mask, state_count, input ready);
    modport sink (input valid, status, goto_valid, goto_state, failure_state,
                  match_mask, state_count, output ready);
endinterface

>>> hdl/mpab_ctrl.sv
// mpab_ctrl: sequencer for clear sweep, load, query and build steps
// depends on mpab_pkg; drives mpab_dp through cmd_t, reads sts_t
module mpab_ctrl (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic [mpab_pkg::OPCODE_W-1:0] in_opcode,
    output logic                          in_ready,
    output logic                          out_valid,
    input  logic                          out_ready,
    output mpab_pkg::cmd_t                cmd,
    input  mpab_pkg::sts_t                sts
);

    logic [mpab_pkg::STEP_W-1:0] state_reg;
    logic [mpab_pkg::STEP_W-1:0] state_next;
    logic                        clear_pending_reg;
    logic                        clear_pending_next;
    logic                        out_valid_reg;
    logic                        out_valid_next;
    logic                        accept;
    logic                        out_load;

    assign in_ready  = (state_reg == mpab_pkg::S_IDLE);
    assign accept    = in_valid && in_ready;
    assign out_load  = (state_reg == mpab_pkg::S_EMIT) && (!out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;

    assign cmd.step     = state_reg;
    assign cmd.accept   = accept;
    assign cmd.out_load = out_load;

    always_comb
    begin
        state_next         = state_reg;
        clear_pending_next = clear_pending_reg;
        out_valid_next     = out_load ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);
        case (state_reg)
            mpab_pkg::S_SWEEP:
            begin
                if (sts.sweep_last)
                begin
                    state_next         = clear_pending_reg ? mpab_pkg::S_EMIT
                                                           : mpab_pkg::S_IDLE;
                    clear_pending_next = 1'b0;
                end
            end
            mpab_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    case (in_opcode)
                        mpab_pkg::OP_CLEAR:
                        begin
                            state_next         = mpab_pkg::S_SWEEP;
                            clear_pending_next = 1'b1;
                        end
                        mpab_pkg::OP_LOAD:
                        begin
                            if (sts.kw_full || sts.discarding)
                                state_next = mpab_pkg::S_EMIT;
                            else
                                state_next = mpab_pkg::S_LD_RD;
                        end
                        mpab_pkg::OP_BUILD: state_next = mpab_pkg::S_B_OWN0_RD;
                        mpab_pkg::OP_QUERY: state_next = mpab_pkg::S_Q_RD;
                        default:            state_next = mpab_pkg::S_IDLE;
                    endcase
                end
            end
            mpab_pkg::S_LD_RD:  state_next = mpab_pkg::S_LD_EV;
            mpab_pkg::S_LD_EV:
                state_next = sts.ld_record ? mpab_pkg::S_LD_ORD : mpab_pkg::S_EMIT;
            mpab_pkg::S_LD_ORD: state_next = mpab_pkg::S_LD_OWR;
            mpab_pkg::S_LD_OWR: state_next = mpab_pkg::S_EMIT;
            mpab_pkg::S_Q_RD:   state_next = mpab_pkg::S_Q_EV;
            mpab_pkg::S_Q_EV:   state_next = mpab_pkg::S_EMIT;
            mpab_pkg::S_B_OWN0_RD: state_next = mpab_pkg::S_B_OWN0_WR;
            mpab_pkg::S_B_OWN0_WR: state_next = mpab_pkg::S_B_R_RD;
            mpab_pkg::S_B_R_RD:    state_next = mpab_pkg::S_B_R_EV;
            mpab_pkg::S_B_R_EV:
            begin
                if (sts.root_enq)
                    state_next = mpab_pkg::S_B_R_WR;
                else
                    state_next = sts.c_last ? mpab_pkg::S_B_Q : mpab_pkg::S_B_R_RD;
            end
            mpab_pkg::S_B_R_WR:
                state_next = sts.c_last ? mpab_pkg::S_B_Q : mpab_pkg::S_B_R_RD;
            mpab_pkg::S_B_Q:
                state_next = sts.head_lt_tail ? mpab_pkg::S_B_S : mpab_pkg::S_EMIT;
            mpab_pkg::S_B_S:    state_next = mpab_pkg::S_B_SF;
            mpab_pkg::S_B_SF:   state_next = mpab_pkg::S_B_C_RD;
            mpab_pkg::S_B_C_RD: state_next = mpab_pkg::S_B_C_EV;
            mpab_pkg::S_B_C_EV:
            begin
                if (sts.e_zero)
                    state_next = sts.c_last ? mpab_pkg::S_B_Q : mpab_pkg::S_B_C_RD;
                else
                    state_next = mpab_pkg::S_B_W_RD;
            end
            mpab_pkg::S_B_W_RD: state_next = mpab_pkg::S_B_W_EV;
            mpab_pkg::S_B_W_EV:
                state_next = sts.e_zero ? mpab_pkg::S_B_W_RD : mpab_pkg::S_B_M_WR;
            mpab_pkg::S_B_M_WR:
                state_next = sts.c_last ? mpab_pkg::S_B_Q : mpab_pkg::S_B_C_RD;
            mpab_pkg::S_EMIT:
            begin
                if (out_load)
                    state_next = mpab_pkg::S_IDLE;
            end
            default: state_next = mpab_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= mpab_pkg::S_SWEEP;
            clear_pending_reg <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            clear_pending_reg <= clear_pending_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    a_clear_sweeps: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (in_opcode == mpab_pkg::OP_CLEAR) |=>
            (state_reg == mpab_pkg::S_SWEEP) && clear_pending_reg)
        else $error("clear request did not start the sweep");

endmodule

>>> hdl/mpab_dp.sv
// mpab_dp: goto, failure, match, keyword-mask and breadth-queue memories
// plus cursors, counters and result registers; depends on mpab_pkg
module mpab_dp #(
    parameter int STATE_LIMIT  = 256,
    parameter int MAX_KEYWORDS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [mpab_pkg::OPCODE_W-1:0] opcode,
    input  logic [mpab_pkg::BYTE_W-1:0]   byte_value,
    input  logic                          end_of_keyword,
    input  logic [mpab_pkg::QSTATE_W-1:0] query_state,
    input  mpab_pkg::cmd_t                cmd,
    output mpab_pkg::sts_t                sts,
    output logic [mpab_pkg::STATUS_W-1:0] status,
    output logic                          goto_valid,
    output logic [mpab_pkg::GSTATE_W-1:0] goto_state,
    output logic [mpab_pkg::FSTATE_W-1:0] failure_state,
    output logic [mpab_pkg::MASK_W-1:0]   match_mask,
    output logic [mpab_pkg::COUNT_W-1:0]  state_count
);

    localparam int SW    = $clog2(STATE_LIMIT);
    localparam int SU    = $clog2(STATE_LIMIT + 1);
    localparam int GA    = SW + 8;
    localparam int KW    = MAX_KEYWORDS;
    localparam int KC    = $clog2(MAX_KEYWORDS + 1);
    localparam int DEPTH = STATE_LIMIT * 256;

    // goto entry: zero absent, otherwise target plus one
    logic [SU-1:0] goto_mem  [DEPTH];
    logic [SW-1:0] fail_mem  [STATE_LIMIT];
    logic [KW-1:0] match_mem [STATE_LIMIT];
    logic [KW-1:0] own_mem   [STATE_LIMIT];
    logic [SW-1:0] queue_mem [STATE_LIMIT];

    logic          goto_re, goto_we;
    logic [GA-1:0] goto_ra, goto_wa;
    logic [SU-1:0] goto_wd, goto_rd_reg;
    logic          fail_re, fail_we;
    logic [SW-1:0] fail_ra, fail_wa, fail_wd, fail_rd_reg;
    logic          match_re, match_we;
    logic [SW-1:0] match_ra, match_wa;
    logic [KW-1:0] match_wd, match_rd_reg;
    logic          own_re, own_we;
    logic [SW-1:0] own_ra, own_wa;
    logic [KW-1:0] own_wd, own_rd_reg;
    logic          queue_re, queue_we;
    logic [SW-1:0] queue_ra, queue_wa, queue_wd, queue_rd_reg;

    logic [GA-1:0] sweep_reg, sweep_next;
    logic [SU-1:0] su_reg, su_next;
    logic [KC-1:0] kw_reg, kw_next;
    logic [SW-1:0] cursor_reg, cursor_next;
    logic          built_reg, built_next;
    logic          discard_reg, discard_next;
    logic [7:0]    c_reg, c_next;
    logic [SU-1:0] head_reg, head_next;
    logic [SU-1:0] tail_reg, tail_next;

    logic [7:0]    byte_reg, byte_next;
    logic          last_reg, last_next;
    logic [7:0]    query_reg, query_next;
    logic [SW-1:0] t_reg, t_next;
    logic [SW-1:0] s_reg, s_next;
    logic [SW-1:0] f_reg, f_next;
    logic [SW-1:0] sf_reg, sf_next;
    logic [KW-1:0] m0_reg, m0_next;

    logic [mpab_pkg::STATUS_W-1:0] res_status_reg, res_status_next;
    logic                          res_gv_reg, res_gv_next;
    logic [mpab_pkg::GSTATE_W-1:0] res_gs_reg, res_gs_next;
    logic [mpab_pkg::FSTATE_W-1:0] res_fs_reg, res_fs_next;
    logic [mpab_pkg::MASK_W-1:0]   res_mm_reg, res_mm_next;

    logic [mpab_pkg::STATUS_W-1:0] out_status_reg, out_status_next;
    logic                          out_gv_reg, out_gv_next;
    logic [mpab_pkg::GSTATE_W-1:0] out_gs_reg, out_gs_next;
    logic [mpab_pkg::FSTATE_W-1:0] out_fs_reg, out_fs_next;
    logic [mpab_pkg::MASK_W-1:0]   out_mm_reg, out_mm_next;
    logic [mpab_pkg::COUNT_W-1:0]  out_cnt_reg, out_cnt_next;

    logic          e_zero, e_ge2, room, tail_room, q_ok;
    logic [SW-1:0] grd_m1, qidx;

    assign e_zero    = (goto_rd_reg == '0);
    assign e_ge2     = (goto_rd_reg > SU'(1));
    assign room      = (32'(su_reg) < STATE_LIMIT);
    assign tail_room = (32'(tail_reg) < STATE_LIMIT);
    assign q_ok      = (32'(query_reg) < 32'(su_reg)) && (32'(query_reg) < STATE_LIMIT);
    assign grd_m1    = SW'(goto_rd_reg - SU'(1));
    assign qidx      = SW'(query_reg);

    assign sts.sweep_last   = &sweep_reg;
    assign sts.kw_full      = (32'(kw_reg) >= MAX_KEYWORDS);
    assign sts.discarding   = discard_reg;
    assign sts.e_zero       = e_zero;
    assign sts.e_ge2        = e_ge2;
    assign sts.root_enq     = e_ge2 && tail_room;
    assign sts.ld_record    = last_reg && (e_ge2 || room);
    assign sts.c_last       = (c_reg == 8'hFF);
    assign sts.head_lt_tail = (head_reg < tail_reg);

    assign status        = out_status_reg;
    assign goto_valid    = out_gv_reg;
    assign goto_state    = out_gs_reg;
    assign failure_state = out_fs_reg;
    assign match_mask    = out_mm_reg;
    assign state_count   = out_cnt_reg;

    always_comb
    begin
        goto_re = 1'b0;  goto_ra = '0;  goto_we = 1'b0;  goto_wa = '0;  goto_wd = '0;
        fail_re = 1'b0;  fail_ra = '0;  fail_we = 1'b0;  fail_wa = '0;  fail_wd = '0;
        match_re = 1'b0; match_ra = '0; match_we = 1'b0; match_wa = '0; match_wd = '0;
        own_re = 1'b0;   own_ra = '0;   own_we = 1'b0;   own_wa = '0;   own_wd = '0;
        queue_re = 1'b0; queue_ra = '0; queue_we = 1'b0; queue_wa = '0; queue_wd = '0;

        sweep_next   = sweep_reg;
        su_next      = su_reg;
        kw_next      = kw_reg;
        cursor_next  = cursor_reg;
        built_next   = built_reg;
        discard_next = discard_reg;
        c_next       = c_reg;
        head_next    = head_reg;
        tail_next    = tail_reg;
        byte_next    = byte_reg;
        last_next    = last_reg;
        query_next   = query_reg;
        t_next       = t_reg;
        s_next       = s_reg;
        f_next       = f_reg;
        sf_next      = sf_reg;
        m0_next      = m0_reg;

        res_status_next = res_status_reg;
        res_gv_next     = res_gv_reg;
        res_gs_next     = res_gs_reg;
        res_fs_next     = res_fs_reg;
        res_mm_next     = res_mm_reg;

        out_status_next = out_status_reg;
        out_gv_next     = out_gv_reg;
        out_gs_next     = out_gs_reg;
        out_fs_next     = out_fs_reg;
        out_mm_next     = out_mm_reg;
        out_cnt_next    = out_cnt_reg;

        case (cmd.step)
            mpab_pkg::S_SWEEP:
            begin
                goto_we = 1'b1;
                goto_wa = sweep_reg;
                if (sweep_reg[7:0] == 8'd0)
                begin
                    own_we   = 1'b1;
                    own_wa   = sweep_reg[GA-1:8];
                    match_we = 1'b1;
                    match_wa = sweep_reg[GA-1:8];
                end
                sweep_next = sweep_reg + GA'(1);
            end
            mpab_pkg::S_IDLE:
            begin
                if (cmd.accept)
                begin
                    byte_next       = byte_value;
                    last_next       = end_of_keyword;
                    query_next      = query_state;
                    res_status_next = mpab_pkg::ST_OK;
                    res_gv_next     = 1'b0;
                    res_gs_next     = '0;
                    res_fs_next     = '0;
                    res_mm_next     = '0;
                    case (opcode)
                        mpab_pkg::OP_CLEAR:
                        begin
                            su_next      = SU'(1);
                            kw_next      = '0;
                            cursor_next  = '0;
                            built_next   = 1'b0;
                            discard_next = 1'b0;
                            sweep_next   = '0;
                        end
                        mpab_pkg::OP_LOAD:
                        begin
                            built_next = 1'b0;
                            if (sts.kw_full)
                                res_status_next = mpab_pkg::ST_KEYWORDS_FULL;
                            else if (discard_reg)
                            begin
                                res_status_next = mpab_pkg::ST_STATES_FULL;
                                if (end_of_keyword)
                                begin
                                    kw_next      = kw_reg + KC'(1);
                                    cursor_next  = '0;
                                    discard_next = 1'b0;
                                end
                            end
                        end
                        mpab_pkg::OP_BUILD:
                        begin
                            cursor_next  = '0;
                            discard_next = 1'b0;
                            c_next       = '0;
                            head_next    = '0;
                            tail_next    = '0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            mpab_pkg::S_LD_RD:
            begin
                goto_re = 1'b1;
                goto_ra = {cursor_reg, byte_reg};
            end
            mpab_pkg::S_LD_EV:
            begin
                if (!e_ge2)
                begin
                    if (!room)
                    begin
                        discard_next    = 1'b1;
                        res_status_next = mpab_pkg::ST_STATES_FULL;
                        if (last_reg)
                        begin
                            kw_next      = kw_reg + KC'(1);
                            cursor_next  = '0;
                            discard_next = 1'b0;
                        end
                    end
                    else
                    begin
                        goto_we     = 1'b1;
                        goto_wa     = {cursor_reg, byte_reg};
                        goto_wd     = SU'(su_reg + SU'(1));
                        cursor_next = SW'(su_reg);
                        su_next     = SU'(su_reg + SU'(1));
                    end
                end
                else
                    cursor_next = grd_m1;
            end
            mpab_pkg::S_LD_ORD:
            begin
                own_re = 1'b1;
                own_ra = cursor_reg;
            end
            mpab_pkg::S_LD_OWR:
            begin
                own_we       = 1'b1;
                own_wa       = cursor_reg;
                own_wd       = own_rd_reg | (KW'(1) << kw_reg);
                kw_next      = kw_reg + KC'(1);
                cursor_next  = '0;
                discard_next = 1'b0;
            end
            mpab_pkg::S_Q_RD:
            begin
                goto_re  = 1'b1;
                goto_ra  = {qidx, byte_reg};
                fail_re  = 1'b1;
                fail_ra  = qidx;
                match_re = 1'b1;
                match_ra = qidx;
            end
            mpab_pkg::S_Q_EV:
            begin
                if (!built_reg)
                    res_status_next = mpab_pkg::ST_NOT_BUILT;
                else if (q_ok)
                begin
                    res_gv_next = !e_zero;
                    res_gs_next = e_zero ? '0 : mpab_pkg::GSTATE_W'(grd_m1);
                    res_fs_next = mpab_pkg::FSTATE_W'(fail_rd_reg);
                    res_mm_next = mpab_pkg::MASK_W'(match_rd_reg);
                end
            end
            mpab_pkg::S_B_OWN0_RD:
            begin
                own_re = 1'b1;
                own_ra = '0;
            end
            mpab_pkg::S_B_OWN0_WR:
            begin
                match_we = 1'b1;
                match_wa = '0;
                match_wd = own_rd_reg;
                m0_next  = own_rd_reg;
                fail_we  = 1'b1;
                fail_wa  = '0;
            end
            mpab_pkg::S_B_R_RD:
            begin
                goto_re = 1'b1;
                goto_ra = {SW'(0), c_reg};
            end
            mpab_pkg::S_B_R_EV:
            begin
                if (e_zero)
                begin
                    goto_we = 1'b1;
                    goto_wa = {SW'(0), c_reg};
                    goto_wd = SU'(1);
                end
                if (sts.root_enq)
                begin
                    t_next = grd_m1;
                    own_re = 1'b1;
                    own_ra = grd_m1;
                end
                else
                    c_next = c_reg + 8'd1;
            end
            mpab_pkg::S_B_R_WR:
            begin
                fail_we   = 1'b1;
                fail_wa   = t_reg;
                match_we  = 1'b1;
                match_wa  = t_reg;
                match_wd  = own_rd_reg | m0_reg;
                queue_we  = 1'b1;
                queue_wa  = tail_reg[SW-1:0];
                queue_wd  = t_reg;
                tail_next = tail_reg + SU'(1);
                c_next    = c_reg + 8'd1;
            end
            mpab_pkg::S_B_Q:
            begin
                if (sts.head_lt_tail)
                begin
                    queue_re  = 1'b1;
                    queue_ra  = head_reg[SW-1:0];
                    head_next = head_reg + SU'(1);
                end
                else
                    built_next = 1'b1;
            end
            mpab_pkg::S_B_S:
            begin
                s_next  = queue_rd_reg;
                fail_re = 1'b1;
                fail_ra = queue_rd_reg;
                c_next  = '0;
            end
            mpab_pkg::S_B_SF:
                sf_next = fail_rd_reg;
            mpab_pkg::S_B_C_RD:
            begin
                goto_re = 1'b1;
                goto_ra = {s_reg, c_reg};
            end
            mpab_pkg::S_B_C_EV:
            begin
                if (e_zero)
                    c_next = c_reg + 8'd1;
                else
                begin
                    t_next = grd_m1;
                    f_next = sf_reg;
                end
            end
            mpab_pkg::S_B_W_RD:
            begin
                goto_re = 1'b1;
                goto_ra = {f_reg, c_reg};
                fail_re = 1'b1;
                fail_ra = f_reg;
            end
            mpab_pkg::S_B_W_EV:
            begin
                if (e_zero)
                    f_next = fail_rd_reg;
                else
                begin
                    fail_we  = 1'b1;
                    fail_wa  = t_reg;
                    fail_wd  = grd_m1;
                    own_re   = 1'b1;
                    own_ra   = t_reg;
                    match_re = 1'b1;
                    match_ra = grd_m1;
                end
            end
            mpab_pkg::S_B_M_WR:
            begin
                match_we = 1'b1;
                match_wa = t_reg;
                match_wd = own_rd_reg | match_rd_reg;
                if (tail_room)
                begin
                    queue_we  = 1'b1;
                    queue_wa  = tail_reg[SW-1:0];
                    queue_wd  = t_reg;
                    tail_next = tail_reg + SU'(1);
                end
                c_next = c_reg + 8'd1;
            end
            default:
            begin
            end
        endcase

        if (cmd.out_load)
        begin
            out_status_next = res_status_reg;
            out_gv_next     = res_gv_reg;
            out_gs_next     = res_gs_reg;
            out_fs_next     = res_fs_reg;
            out_mm_next     = res_mm_reg;
            out_cnt_next    = mpab_pkg::COUNT_W'(su_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (goto_we)
            goto_mem[goto_wa] <= goto_wd;
        if (goto_re)
            goto_rd_reg <= goto_mem[goto_ra];
    end

    always_ff @(posedge clk)
    begin
        if (fail_we)
            fail_mem[fail_wa] <= fail_wd;
        if (fail_re)
            fail_rd_reg <= fail_mem[fail_ra];
    end

    always_ff @(posedge clk)
    begin
        if (match_we)
            match_mem[match_wa] <= match_wd;
        if (match_re)
            match_rd_reg <= match_mem[match_ra];
    end

    always_ff @(posedge clk)
    begin
        if (own_we)
            own_mem[own_wa] <= own_wd;
        if (own_re)
            own_rd_reg <= own_mem[own_ra];
    end

    always_ff @(posedge clk)
    begin
        if (queue_we)
            queue_mem[queue_wa] <= queue_wd;
        if (queue_re)
            queue_rd_reg <= queue_mem[queue_ra];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sweep_reg   <= '0;
            su_reg      <= SU'(1);
            kw_reg      <= '0;
            cursor_reg  <= '0;
            built_reg   <= 1'b0;
            discard_reg <= 1'b0;
            c_reg       <= '0;
            head_reg    <= '0;
            tail_reg    <= '0;
        end
        else
        begin
            sweep_reg   <= sweep_next;
            su_reg      <= su_next;
            kw_reg      <= kw_next;
            cursor_reg  <= cursor_next;
            built_reg   <= built_next;
            discard_reg <= discard_next;
            c_reg       <= c_next;
            head_reg    <= head_next;
            tail_reg    <= tail_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg       <= byte_next;
        last_reg       <= last_next;
        query_reg      <= query_next;
        t_reg          <= t_next;
        s_reg          <= s_next;
        f_reg          <= f_next;
        sf_reg         <= sf_next;
        m0_reg         <= m0_next;
        res_status_reg <= res_status_next;
        res_gv_reg     <= res_gv_next;
        res_gs_reg     <= res_gs_next;
        res_fs_reg     <= res_fs_next;
        res_mm_reg     <= res_mm_next;
        out_status_reg <= out_status_next;
        out_gv_reg     <= out_gv_next;
        out_gs_reg     <= out_gs_next;
        out_fs_reg     <= out_fs_next;
        out_mm_reg     <= out_mm_next;
        out_cnt_reg    <= out_cnt_next;
    end

    a_states_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (su_reg != '0) && (32'(su_reg) <= STATE_LIMIT))
        else $error("state count out of range");

    a_keywords_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        32'(kw_reg) <= MAX_KEYWORDS)
        else $error("keyword count out of range");

    a_queue_order: assert property (@(posedge clk) disable iff (!rst_n)
        head_reg <= tail_reg)
        else $error("breadth queue head passed tail");

    a_cursor_in_use: assert property (@(posedge clk) disable iff (!rst_n)
        SU'(cursor_reg) < su_reg)
        else $error("insert cursor points past used states");

endmodule

>>> hdl/multi_pattern_automaton_builder.sv
// multi_pattern_automaton_builder: keyword trie loader and failure-link builder
// depends on mpab_pkg, mpab_ifs (channels), mpab_ctrl and mpab_dp
//
//   channel  dir  handshake    payload
//   req      in   valid/ready  opcode, byte_value, end_of_keyword, query_state
//   rsp      out  valid/ready  status, goto_valid, goto_state, failure_state,
//                              match_mask, state_count
//
// one request in flight; every request gives one rsp item
// load reads and evaluates the goto entry unless refused at once, then reads and
// writes the own mask when it records a keyword end; query reads, then evaluates
// build reads and evaluates each root byte, writing a queued child, then per queued
// state reads its failure link and each byte's goto entry, walking the failure chain
// hop by hop for each child; the goto memory's single read port sets its pace
// clear and reset sweep the goto memory and zero the own and match masks, req stalled
// req is taken again while a finished rsp still waits on rsp.ready
module multi_pattern_automaton_builder #(
    parameter int STATE_LIMIT  = 256,
    parameter int MAX_KEYWORDS = 16
) (
    input logic        clk,
    input logic        rst_n,
    mpab_req_if.sink   req,
    mpab_rsp_if.source rsp
);

    mpab_pkg::cmd_t cmd;
    mpab_pkg::sts_t sts;

    mpab_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_opcode (req.opcode),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .cmd       (cmd),
        .sts       (sts)
    );

    mpab_dp #(
        .STATE_LIMIT  (STATE_LIMIT),
        .MAX_KEYWORDS (MAX_KEYWORDS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .opcode         (req.opcode),
        .byte_value     (req.byte_value),
        .end_of_keyword (req.end_of_keyword),
        .query_state    (req.query_state),
        .cmd            (cmd),
        .sts            (sts),
        .status         (rsp.status),
        .goto_valid     (rsp.goto_valid),
        .goto_state     (rsp.goto_state),
        .failure_state  (rsp.failure_state),
        .match_mask     (rsp.match_mask),
        .state_count    (rsp.state_count)
    );

endmodule

>>> verif/tb.sv
// tb: self-checking testbench for multi_pattern_automaton_builder
// drives requests over mpab_req_if, checks results on mpab_rsp_if against an internal predictor
// depends on mpab_pkg, mpab_ifs and the rtl of the block
`timescale 1ns / 1ps
module tb;

    localparam int N_STATES    = 256;
    localparam int N_KEYWORDS  = 16;
    localparam int CYCLE_LIMIT = 6000000;

    typedef struct packed {
        logic [mpab_pkg::OPCODE_W-1:0] opcode;
        logic [mpab_pkg::BYTE_W-1:0]   byte_value;
        logic                          end_of_keyword;
        logic [mpab_pkg::QSTATE_W-1:0] query_state;
    } req_t;

    typedef struct packed {
        logic [mpab_pkg::STATUS_W-1:0] status;
        logic                          goto_valid;
        logic [mpab_pkg::GSTATE_W-1:0] goto_state;
        logic [mpab_pkg::FSTATE_W-1:0] failure_state;
        logic [mpab_pkg::MASK_W-1:0]   match_mask;
        logic [mpab_pkg::COUNT_W-1:0]  state_count;
    } rsp_t;

    typedef struct packed {
        req_t r;
        bit   typed;
        rsp_t e;
    } dir_row_t;

    logic clk;
    logic rst_n;

    mpab_req_if req ();
    mpab_rsp_if rsp ();

    multi_pattern_automaton_builder #(
        .STATE_LIMIT  (N_STATES),
        .MAX_KEYWORDS (N_KEYWORDS)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req.sink),
        .rsp   (rsp.source)
    );

    always #1 clk = ~clk;

    // trie entry: 0 absent, else target + 1
    bit [8:0]        trie_goto [0:65535];
    bit [7:0]        fail_link [0:255];
    bit [15:0]       merged_mask [0:255];
    bit [15:0]       own_mask [0:255];
    bit [7:0]        bfs_order [0:255];
    int              states_in_use;
    int              keyword_count;
    int              cursor;
    bit              automaton_ready;
    bit              dropping;

    rsp_t            pending_rsps[$];
    int              cycles;
    int              errors;
    int              requests_sent;
    int              results_seen;
    int              builds_sent;
    int              burst_left;
    bit              no_idle;
    int              hold_asked;
    int              hold_done;
    int              hold_left;
    int              calm_left;

    function automatic void clear_automaton();
        int i;
        for (i = 0; i < 65536; i++)
            trie_goto[i] = '0;
        for (i = 0; i < N_STATES; i++)
        begin
            fail_link[i]   = '0;
            merged_mask[i] = '0;
            own_mask[i]    = '0;
            bfs_order[i]   = '0;
        end
        states_in_use   = 1;
        keyword_count   = 0;
        cursor          = 0;
        automaton_ready = 1'b0;
        dropping        = 1'b0;
    endfunction

    function automatic void close_keyword(bit record);
        if (record)
            own_mask[cursor][keyword_count % 16] = 1'b1;
        keyword_count++;
        cursor   = 0;
        dropping = 1'b0;
    endfunction

    function automatic logic [mpab_pkg::STATUS_W-1:0] insert_byte(int b, bit last);
        int idx;
        int e;
        if (keyword_count >= N_KEYWORDS)
            return mpab_pkg::ST_KEYWORDS_FULL;
        if (dropping)
        begin
            if (last)
                close_keyword(1'b0);
            return mpab_pkg::ST_STATES_FULL;
        end
        idx = cursor * 256 + b;
        e   = int'(trie_goto[idx]);
        if (e <= 1)
        begin
            if (states_in_use >= N_STATES)
            begin
                dropping = 1'b1;
                if (last)
                    close_keyword(1'b0);
                return mpab_pkg::ST_STATES_FULL;
            end
            trie_goto[idx] = 9'(states_in_use + 1);
            cursor         = states_in_use;
            states_in_use++;
        end
        else
            cursor = e - 1;
        if (last)
            close_keyword(1'b1);
        return mpab_pkg::ST_OK;
    endfunction

    function automatic void build_automaton();
        int head;
        int tail;
        int c;
        int s;
        int t;
        int f;
        int e;
        int i;
        head     = 0;
        tail     = 0;
        cursor   = 0;
        dropping = 1'b0;
        for (c = 0; c < 256; c++)
            if (trie_goto[c] == 0)
                trie_goto[c] = 9'd1;
        fail_link[0]   = '0;
        merged_mask[0] = own_mask[0];
        for (c = 0; c < 256; c++)
        begin
            t = int'(trie_goto[c]) - 1;
            if (t != 0 && tail < N_STATES)
            begin
                fail_link[t]      = '0;
                merged_mask[t]    = own_mask[t] | merged_mask[0];
                bfs_order[tail++] = 8'(t);
            end
        end
        while (head < tail)
        begin
            s = int'(bfs_order[head++]);
            for (c = 0; c < 256; c++)
            begin
                e = int'(trie_goto[s * 256 + c]);
                if (e == 0)
                    continue;
                t = (e - 1) % N_STATES;
                f = int'(fail_link[s]);
                for (i = 0; i < N_STATES && trie_goto[f * 256 + c] == 0; i++)
                    f = int'(fail_link[f]);
                f = int'(trie_goto[f * 256 + c]);
                f = (f == 0) ? 0 : (f - 1) % N_STATES;
                fail_link[t]   = 8'(f);
                merged_mask[t] = own_mask[t] | merged_mask[f];
                if (tail < N_STATES)
                    bfs_order[tail++] = 8'(t);
            end
        end
        automaton_ready = 1'b1;
    endfunction

    function automatic rsp_t predict(req_t r);
        rsp_t p;
        int e;
        p = '0;
        case (r.opcode)
            mpab_pkg::OP_CLEAR: clear_automaton();
            mpab_pkg::OP_LOAD:
            begin
                automaton_ready = 1'b0;
                p.status = insert_byte(int'(r.byte_value), r.end_of_keyword);
            end
            mpab_pkg::OP_BUILD: build_automaton();
            default:
            begin
                if (!automaton_ready)
                    p.status = mpab_pkg::ST_NOT_BUILT;
                else if (int'(r.query_state) < states_in_use)
                begin
                    e = int'(trie_goto[int'(r.query_state) * 256 + int'(r.byte_value)]);
                    if (e != 0)
                    begin
                        p.goto_valid = 1'b1;
                        p.goto_state = 8'(e - 1);
                    end
                    p.failure_state = fail_link[r.query_state];
                    p.match_mask    = merged_mask[r.query_state];
                end
            end
        endcase
        p.state_count = 9'(states_in_use);
        return p;
    endfunction

    function automatic req_t mk(logic [mpab_pkg::OPCODE_W-1:0] op, int b, bit last, int q);
        req_t r;
        r.opcode         = op;
        r.byte_value     = 8'(b);
        r.end_of_keyword = last;
        r.query_state    = 8'(q);
        return r;
    endfunction

    function automatic int pick_byte(int base);
        if ($urandom_range(0, 7) == 0)
            return int'($urandom_range(0, 255));
        return int'((base + $urandom_range(0, 3)) % 256);
    endfunction

    task automatic send(req_t r, rsp_t typed, bit has_typed);
        rsp_t p;
        req.valid          <= 1'b1;
        req.opcode         <= r.opcode;
        req.byte_value     <= r.byte_value;
        req.end_of_keyword <= r.end_of_keyword;
        req.query_state    <= r.query_state;
        do
            @(negedge clk);
        while (!req.ready);
        @(posedge clk);
        p = predict(r);
        pending_rsps.insert(pending_rsps.size(), has_typed ? typed : p);
        requests_sent++;
        if (r.opcode == mpab_pkg::OP_BUILD)
            builds_sent++;
        if (!no_idle)
        begin
            if (burst_left == 0)
            begin
                req.valid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge clk);
                burst_left = $urandom_range(1, 30);
            end
            else
                burst_left--;
        end
    endtask

    task automatic drain();
        req.valid <= 1'b0;
        @(posedge clk);
        while (pending_rsps.size() != 0)
            @(posedge clk);
    endtask

    task automatic run_episode(int n_kw, bit ask_hold);
        int k;
        int j;
        int len;
        int n_q;
        int x;
        int base;
        base = $urandom_range(0, 255);
        send(mk(mpab_pkg::OP_CLEAR, $urandom_range(0, 255), 1'b0, $urandom_range(0, 255)),
             '0, 1'b0);
        for (k = 0; k < n_kw; k++)
        begin
            len = $urandom_range(1, 3);
            for (j = 0; j < len; j++)
                send(mk(mpab_pkg::OP_LOAD, pick_byte(base), j == len - 1,
                        $urandom_range(0, 255)), '0, 1'b0);
            if ($urandom_range(0, 7) == 0)
                send(mk(mpab_pkg::OP_QUERY, $urandom_range(0, 255), 1'b0,
                        $urandom_range(0, 255)), '0, 1'b0);
        end
        if ($urandom_range(0, 1) == 0)
            drain();
        send(mk(mpab_pkg::OP_BUILD, $urandom_range(0, 255), $urandom_range(0, 1) == 1, 0),
             '0, 1'b0);
        n_q = $urandom_range(170, 200);
        for (j = 0; j < n_q; j++)
        begin
            if (ask_hold && j == 40)
                hold_asked++;
            x = $urandom_range(0, 99);
            if (x < 3)
                send(mk(mpab_pkg::OP_LOAD, pick_byte(base), $urandom_range(0, 1) == 1, 0),
                     '0, 1'b0);
            else if (x < 5)
                send(mk(mpab_pkg::OP_BUILD, 0, 1'b0, 0), '0, 1'b0);
            else if ($urandom_range(0, 9) == 0)
                send(mk(mpab_pkg::OP_QUERY, $urandom_range(0, 255), $urandom_range(0, 1) == 1,
                        $urandom_range(0, 255)), '0, 1'b0);
            else
                send(mk(mpab_pkg::OP_QUERY, pick_byte(base), $urandom_range(0, 1) == 1,
                        $urandom_range(0, states_in_use - 1)), '0, 1'b0);
        end
    endtask

    // distinct first bytes, so each keyword needs its own chain of states
    task automatic run_overflow_episode();
        int k;
        int j;
        send(mk(mpab_pkg::OP_CLEAR, 0, 1'b0, 0), '0, 1'b0);
        for (k = 0; k < N_KEYWORDS; k++)
            for (j = 0; j < 17; j++)
                send(mk(mpab_pkg::OP_LOAD, (k * 17 + j) % 256, j == 16, 0), '0, 1'b0);
        for (k = 0; k < 3; k++)
            send(mk(mpab_pkg::OP_LOAD, $urandom_range(0, 255), k == 2, 0), '0, 1'b0);
        send(mk(mpab_pkg::OP_BUILD, 0, 1'b0, 0), '0, 1'b0);
        for (k = 0; k < 60; k++)
            send(mk(mpab_pkg::OP_QUERY, $urandom_range(0, 255), 1'b0, $urandom_range(0, 255)),
                 '0, 1'b0);
    endtask

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results pending", cycles, pending_rsps.size());
            $display("status: fail");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            rsp.ready <= 1'b0;
            hold_left--;
        end
        else if (hold_asked != hold_done)
        begin
            hold_done++;
            hold_left = 400;
            rsp.ready <= 1'b0;
        end
        else if (calm_left > 0)
        begin
            rsp.ready <= 1'b1;
            calm_left--;
        end
        else
        begin
            if ($urandom_range(0, 31) == 0)
                calm_left = $urandom_range(20, 100);
            rsp.ready <= ($urandom_range(0, 3) != 0);
        end
    end

    always @(negedge clk)
    begin
        rsp_t e;
        if (rst_n && rsp.valid && rsp.ready)
        begin
            results_seen++;
            if (pending_rsps.size() == 0)
            begin
                $error("result with no request waiting");
                errors++;
            end
            else
            begin
                e = pending_rsps.pop_front();
                if (rsp.status !== e.status)
                begin
                    $error("status: expected %0d, got %0d", e.status, rsp.status);
                    errors++;
                end
                if (rsp.goto_valid !== e.goto_valid)
                begin
                    $error("goto_valid: expected %0d, got %0d", e.goto_valid, rsp.goto_valid);
                    errors++;
                end
                if (rsp.goto_state !== e.goto_state)
                begin
                    $error("goto_state: expected %0d, got %0d", e.goto_state, rsp.goto_state);
                    errors++;
                end
                if (rsp.failure_state !== e.failure_state)
                begin
                    $error("failure_state: expected %0d, got %0d", e.failure_state,
                           rsp.failure_state);
                    errors++;
                end
                if (rsp.match_mask !== e.match_mask)
                begin
                    $error("match_mask: expected %h, got %h", e.match_mask, rsp.match_mask);
                    errors++;
                end
                if (rsp.state_count !== e.state_count)
                begin
                    $error("state_count: expected %0d, got %0d", e.state_count, rsp.state_count);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        dir_row_t dir_rows [18];
        int i;
        clk                = 1'b0;
        rst_n              = 1'b0;
        req.valid          = 1'b0;
        req.opcode         = mpab_pkg::OP_CLEAR;
        req.byte_value     = '0;
        req.end_of_keyword = 1'b0;
        req.query_state    = '0;
        rsp.ready          = 1'b0;
        cycles             = 0;
        errors             = 0;
        requests_sent      = 0;
        results_seen       = 0;
        builds_sent        = 0;
        burst_left         = 0;
        no_idle            = 1'b0;
        hold_asked         = 0;
        hold_done          = 0;
        hold_left          = 0;
        calm_left          = 0;
        clear_automaton();

        dir_rows = '{
            // query before any build
            '{mk(mpab_pkg::OP_QUERY, 0, 1'b0, 0), 1'b1,
              '{mpab_pkg::ST_NOT_BUILT, 1'b0, 8'd0, 8'd0, 16'd0, 9'd1}},
            // build of an empty trie
            '{mk(mpab_pkg::OP_BUILD, 0, 1'b0, 0), 1'b1,
              '{mpab_pkg::ST_OK, 1'b0, 8'd0, 8'd0, 16'd0, 9'd1}},
            '{mk(mpab_pkg::OP_QUERY, 8'hff, 1'b1, 0), 1'b1,
              '{mpab_pkg::ST_OK, 1'b1, 8'd0, 8'd0, 16'd0, 9'd1}},
            // state not in use
            '{mk(mpab_pkg::OP_QUERY, 0, 1'b0, 8'hff), 1'b1,
              '{mpab_pkg::ST_OK, 1'b0, 8'd0, 8'd0, 16'd0, 9'd1}},
            '{mk(mpab_pkg::OP_LOAD, 8'h00, 1'b0, 8'hff), 1'b0, '0},
            '{mk(mpab_pkg::OP_LOAD, 8'hff, 1'b1, 0), 1'b0, '0},
            '{mk(mpab_pkg::OP_LOAD, 8'hff, 1'b1, 0), 1'b0, '0},
            '{mk(mpab_pkg::OP_LOAD, 8'h00, 1'b0, 0), 1'b0, '0},
            '{mk(mpab_pkg::OP_LOAD, 8'h00, 1'b1, 0), 1'b0, '0},
            // unfinished keyword abandoned by build
            '{mk(mpab_pkg::OP_LOAD, 8'h55, 1'b0, 0), 1'b0, '0},
            '{mk(mpab_pkg::OP_BUILD, 8'hff, 1'b1, 8'hff), 1'b0, '0},
            '{mk(mpab_pkg::OP_QUERY, 8'hff, 1'b0, 1), 1'b0, '0},
            '{mk(mpab_pkg::OP_QUERY, 8'h00, 1'b0, 4), 1'b0, '0},
            // load after build, root self loop counts as absent
            '{mk(mpab_pkg::OP_LOAD, 8'h80, 1'b1, 0), 1'b0, '0},
            '{mk(mpab_pkg::OP_QUERY, 8'h80, 1'b0, 0), 1'b0, '0},
            '{mk(mpab_pkg::OP_BUILD, 0, 1'b0, 0), 1'b0, '0},
            '{mk(mpab_pkg::OP_QUERY, 8'h80, 1'b0, 0), 1'b0, '0},
            '{mk(mpab_pkg::OP_QUERY, 8'haa, 1'b1, 8'h06), 1'b0, '0}
        };

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (i = 0; i < 18; i++)
            send(dir_rows[i].r, dir_rows[i].e, dir_rows[i].typed);
        drain();

        run_episode(18, 1'b1);
        drain();
        run_episode(12, 1'b0);
        no_idle = 1'b1;
        run_episode(16, 1'b0);
        no_idle = 1'b0;
        run_episode(20, 1'b1);
        run_overflow_episode();
        drain();
        run_episode(14, 1'b0);
        no_idle = 1'b1;
        run_episode(17, 1'b0);
        no_idle = 1'b0;

        req.valid <= 1'b0;
        while (pending_rsps.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);

        $display("%0d requests sent, %0d results checked, %0d builds, %0d errors",
                 requests_sent, results_seen, builds_sent, errors);
        $display("covered clears, keyword and state overflow, rebuilds and long result stalls");
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
